// ===== design/delta_arm_inverse_kinematics_defines.svh =====
// assertion macros for the delta arm inverse kinematics block
`ifndef DELTA_ARM_INVERSE_KINEMATICS_DEFINES_SVH
`define DELTA_ARM_INVERSE_KINEMATICS_DEFINES_SVH

// same-cycle implication, checked while out of reset
`define DAIK_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked while out of reset
`define DAIK_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/daik_pkg.sv =====
// shared types, constants and tables of the delta arm inverse kinematics block
package daik_pkg;

    typedef logic signed [19:0] angle_t;

    // status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_SING = 2'd1;
    localparam logic [1:0] ST_MISS = 2'd2;

    // register indexes
    localparam logic [2:0] REG_BASE  = 3'd0;
    localparam logic [2:0] REG_PLAT  = 3'd1;
    localparam logic [2:0] REG_UPPER = 3'd2;
    localparam logic [2:0] REG_LOWER = 3'd3;
    localparam logic [2:0] REG_OFS0  = 3'd4;
    localparam logic [2:0] REG_OFS1  = 3'd5;
    localparam logic [2:0] REG_OFS2  = 3'd6;

    // sin(120 deg) and one half in q30
    localparam logic [29:0] SIN120_Q30 = 30'd929887697;
    localparam logic signed [53:0] HALF_Q30 = 54'sd536870912;

    // ANG_90 in 1/16 millidegree, ANG_LIMIT in millidegrees
    localparam logic signed [23:0] ANG_90 = 24'sd1440000;
    localparam angle_t ANG_LIMIT = 20'sd360000;

    localparam logic [4:0] CORDIC_LAST = 5'd19;

    // cordic arctangent table, 1/16 millidegree
    function automatic logic [19:0] atan_entry(input logic [4:0] i);
        logic [19:0] v;
        begin
            case (i)
                5'd0:    v = 20'd720000;
                5'd1:    v = 20'd425041;
                5'd2:    v = 20'd224580;
                5'd3:    v = 20'd114000;
                5'd4:    v = 20'd57221;
                5'd5:    v = 20'd28639;
                5'd6:    v = 20'd14323;
                5'd7:    v = 20'd7162;
                5'd8:    v = 20'd3581;
                5'd9:    v = 20'd1790;
                5'd10:   v = 20'd895;
                5'd11:   v = 20'd448;
                5'd12:   v = 20'd224;
                5'd13:   v = 20'd112;
                5'd14:   v = 20'd56;
                5'd15:   v = 20'd28;
                5'd16:   v = 20'd14;
                5'd17:   v = 20'd7;
                5'd18:   v = 20'd3;
                5'd19:   v = 20'd2;
                default: v = 20'd0;
            endcase
            return v;
        end
    endfunction

endpackage

// ===== design/delta_arm_inverse_kinematics.sv =====
// delta arm inverse kinematics: target position to three motor angles
`include "delta_arm_inverse_kinematics_defines.svh"

// Takes one request at a time. A stop request presents its result in the cycle after
// acceptance. A solve request runs the rotation states S_R1, S_R2 and S_R3 and then,
// for each leg in turn, multiply and add steps on one shared 33x33 multiplier, a
// one-bit-per-cycle square root used twice, a restoring divider and one 20-step
// cordic unit used for both arctangents. A failing leg ends the request early.
// The result is held at the output until taken. On a failure the held angles
// are kept and the first failing leg is reported.
module delta_arm_inverse_kinematics
    import daik_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // request channel
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               mode,
    input  logic signed [20:0] target_x,
    input  logic signed [20:0] target_y,
    input  logic signed [20:0] target_z,
    // result channel
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [19:0] motor_angle_0,
    output logic signed [19:0] motor_angle_1,
    output logic signed [19:0] motor_angle_2,
    output logic [1:0]         status,
    output logic [1:0]         failed_leg,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    // sequencer states
    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_R1   = 5'd1;
    localparam logic [4:0] S_R2   = 5'd2;
    localparam logic [4:0] S_R3   = 5'd3;
    localparam logic [4:0] S_LEG  = 5'd4;
    localparam logic [4:0] S_LY   = 5'd5;
    localparam logic [4:0] S_MYY  = 5'd6;
    localparam logic [4:0] S_MZZ  = 5'd7;
    localparam logic [4:0] S_MRX  = 5'd8;
    localparam logic [4:0] S_MRE  = 5'd9;
    localparam logic [4:0] S_MRF  = 5'd10;
    localparam logic [4:0] S_CHK  = 5'd11;
    localparam logic [4:0] S_SQ1  = 5'd12;
    localparam logic [4:0] S_MD   = 5'd13;
    localparam logic [4:0] S_MDC  = 5'd14;
    localparam logic [4:0] S_DIV0 = 5'd15;
    localparam logic [4:0] S_DIV  = 5'd16;
    localparam logic [4:0] S_MQQ  = 5'd17;
    localparam logic [4:0] S_SQ2L = 5'd18;
    localparam logic [4:0] S_SQ2  = 5'd19;
    localparam logic [4:0] S_C1   = 5'd20;
    localparam logic [4:0] S_C2   = 5'd21;
    localparam logic [4:0] S_SEL  = 5'd22;
    localparam logic [4:0] S_OFS  = 5'd23;
    localparam logic [4:0] S_OUT  = 5'd24;

    localparam logic [4:0] SQRT_LAST = 5'd31;
    localparam logic [4:0] DIV_LAST  = 5'd29;
    localparam logic [63:0] SQRT_ONE = 64'h4000_0000_0000_0000;
    localparam logic [63:0] ONE_Q60  = 64'h1000_0000_0000_0000;

    // control registers
    logic [4:0]  state_reg;
    logic [4:0]  cnt_reg;
    logic [1:0]  leg_reg;
    angle_t      held_reg [3];
    logic [1:0]  status_reg;
    logic [1:0]  failed_reg;

    // configuration registers
    logic [19:0]        base_reg;
    logic [19:0]        plat_reg;
    logic [19:0]        upper_reg;
    logic [19:0]        lower_reg;
    logic signed [18:0] ofs_reg [3];

    // datapath registers
    logic signed [20:0] x_reg, y_reg, z_reg;
    logic signed [51:0] px_reg, py_reg;
    logic signed [65:0] prod_reg;
    logic signed [21:0] rx_reg, ry_reg;
    logic signed [22:0] yv_reg;
    logic [45:0]        rho_reg;
    logic signed [47:0] n_reg;
    logic [53:0]        d_reg;
    logic [54:0]        r_reg;
    logic [30:0]        q_reg;
    logic [63:0]        sv_reg, sres_reg, sone_reg;
    logic signed [35:0] cx_reg, cy_reg;
    logic signed [23:0] cacc_reg;
    logic signed [23:0] phi_reg;
    logic signed [20:0] th_reg;
    angle_t             nang_reg [3];

    // shared multiplier operand select
    logic signed [32:0] mul_a, mul_b;
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_R1:
            begin
                mul_a = 33'(x_reg);
                mul_b = $signed({3'b000, SIN120_Q30});
            end
            S_R2:
            begin
                mul_a = 33'(y_reg);
                mul_b = $signed({3'b000, SIN120_Q30});
            end
            S_MYY:
            begin
                mul_a = 33'(yv_reg);
                mul_b = 33'(yv_reg);
            end
            S_MZZ:
            begin
                mul_a = 33'(z_reg);
                mul_b = 33'(z_reg);
            end
            S_MRX:
            begin
                mul_a = 33'(rx_reg);
                mul_b = 33'(rx_reg);
            end
            S_MRE:
            begin
                mul_a = $signed({13'd0, lower_reg});
                mul_b = $signed({13'd0, lower_reg});
            end
            S_MRF:
            begin
                mul_a = $signed({13'd0, upper_reg});
                mul_b = $signed({13'd0, upper_reg});
            end
            S_MD:
            begin
                mul_a = $signed({13'd0, upper_reg});
                mul_b = $signed({1'b0, sres_reg[31:0]});
            end
            S_MQQ:
            begin
                mul_a = $signed({2'b00, q_reg});
                mul_b = $signed({2'b00, q_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // leg plane rotation terms
    logic signed [53:0] x29, y29, pxe, pye, rx_sum, ry_sum;
    always_comb
    begin
        x29 = 54'(x_reg) <<< 29;
        y29 = 54'(y_reg) <<< 29;
        pxe = 54'(px_reg);
        pye = 54'(py_reg);
        if (leg_reg == 2'd1)
        begin
            rx_sum = -x29 + pye + HALF_Q30;
            ry_sum = -pxe - y29 + HALF_Q30;
        end
        else
        begin
            rx_sum = -x29 - pye + HALF_Q30;
            ry_sum = pxe - y29 + HALF_Q30;
        end
    end

    // square root step
    logic [63:0] sq_sum;
    logic        sq_ge;
    assign sq_sum = sres_reg + sone_reg;
    assign sq_ge  = sv_reg >= sq_sum;

    // circle miss check and divider step
    logic [47:0] n_abs;
    logic [53:0] num_val, d_val;
    logic        mdc_miss;
    logic [54:0] dv_r2;
    logic        dv_ge;
    assign n_abs    = n_reg[47] ? 48'(-n_reg) : 48'(n_reg);
    assign num_val  = {n_abs[45:0], 8'd0};
    assign d_val    = {prod_reg[52:0], 1'b0};
    assign mdc_miss = num_val > d_val;
    assign dv_r2    = {r_reg[53:0], 1'b0};
    assign dv_ge    = dv_r2 >= {1'b0, d_reg};

    // cordic load with quadrant pre-rotation
    logic signed [35:0] ld_y, ld_x, ld_cx, ld_cy;
    logic signed [23:0] ld_acc;
    logic signed [31:0] m_val;
    always_comb
    begin
        m_val = n_reg[47] ? -$signed({1'b0, q_reg}) : $signed({1'b0, q_reg});
        if (state_reg == S_SQ2)
        begin
            ld_y = 36'(z_reg) <<< 8;
            ld_x = 36'(yv_reg) <<< 8;
        end
        else
        begin
            ld_y = $signed({5'd0, sres_reg[30:0]});
            ld_x = 36'(m_val);
        end
        if (ld_x < 0)
        begin
            if (ld_y >= 0)
            begin
                ld_cx  = ld_y;
                ld_cy  = -ld_x;
                ld_acc = ANG_90;
            end
            else
            begin
                ld_cx  = -ld_y;
                ld_cy  = ld_x;
                ld_acc = -ANG_90;
            end
        end
        else
        begin
            ld_cx  = ld_x;
            ld_cy  = ld_y;
            ld_acc = '0;
        end
    end

    // cordic vectoring step
    logic signed [35:0] c_dx, c_dy, c_x_step, c_y_step;
    logic signed [23:0] c_tab, c_acc_step;
    always_comb
    begin
        c_dx  = cx_reg >>> cnt_reg;
        c_dy  = cy_reg >>> cnt_reg;
        c_tab = $signed({4'd0, atan_entry(cnt_reg)});
        if (cy_reg > 0)
        begin
            c_x_step   = cx_reg + c_dy;
            c_y_step   = cy_reg - c_dx;
            c_acc_step = cacc_reg + c_tab;
        end
        else
        begin
            c_x_step   = cx_reg - c_dy;
            c_y_step   = cy_reg + c_dx;
            c_acc_step = cacc_reg - c_tab;
        end
    end

    // root choice and millidegree rounding
    logic signed [24:0] th0, th1, th0_abs, th1_abs, th_pick, th_rnd;
    always_comb
    begin
        th0     = 25'(phi_reg) + 25'(cacc_reg);
        th1     = 25'(phi_reg) - 25'(cacc_reg);
        th0_abs = th0[24] ? -th0 : th0;
        th1_abs = th1[24] ? -th1 : th1;
        th_pick = (th1_abs < th0_abs) ? th1 : th0;
        th_rnd  = (th_pick + 25'sd8) >>> 4;
    end

    // home offset and saturation
    logic signed [21:0] ofs_sum;
    angle_t             ofs_sat;
    logic signed [18:0] ofs_cur;
    always_comb
    begin
        case (leg_reg)
            2'd0:    ofs_cur = ofs_reg[0];
            2'd1:    ofs_cur = ofs_reg[1];
            default: ofs_cur = ofs_reg[2];
        endcase
        ofs_sum = 22'(th_reg) + 22'(ofs_cur);
        if (ofs_sum > 22'(ANG_LIMIT))
            ofs_sat = ANG_LIMIT;
        else if (ofs_sum < -22'(ANG_LIMIT))
            ofs_sat = -ANG_LIMIT;
        else
            ofs_sat = 20'(ofs_sum);
    end

    // sequencer, held angles and status
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            leg_reg     <= '0;
            held_reg[0] <= '0;
            held_reg[1] <= '0;
            held_reg[2] <= '0;
            status_reg  <= ST_OK;
            failed_reg  <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        if (mode)
                        begin
                            held_reg[0] <= '0;
                            held_reg[1] <= '0;
                            held_reg[2] <= '0;
                            status_reg  <= ST_OK;
                            failed_reg  <= '0;
                            state_reg   <= S_OUT;
                        end
                        else
                        begin
                            leg_reg   <= '0;
                            state_reg <= S_R1;
                        end
                    end
                end
                S_R1:  state_reg <= S_R2;
                S_R2:  state_reg <= S_R3;
                S_R3:  state_reg <= S_LEG;
                S_LEG: state_reg <= S_LY;
                S_LY:  state_reg <= S_MYY;
                S_MYY: state_reg <= S_MZZ;
                S_MZZ: state_reg <= S_MRX;
                S_MRX: state_reg <= S_MRE;
                S_MRE: state_reg <= S_MRF;
                S_MRF: state_reg <= S_CHK;
                S_CHK:
                begin
                    cnt_reg <= '0;
                    if (rho_reg == '0)
                    begin
                        status_reg <= ST_SING;
                        failed_reg <= leg_reg;
                        state_reg  <= S_OUT;
                    end
                    else if (upper_reg == '0)
                    begin
                        status_reg <= ST_MISS;
                        failed_reg <= leg_reg;
                        state_reg  <= S_OUT;
                    end
                    else
                    begin
                        state_reg <= S_SQ1;
                    end
                end
                S_SQ1:
                begin
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == SQRT_LAST)
                        state_reg <= S_MD;
                end
                S_MD: state_reg <= S_MDC;
                S_MDC:
                begin
                    if (mdc_miss)
                    begin
                        status_reg <= ST_MISS;
                        failed_reg <= leg_reg;
                        state_reg  <= S_OUT;
                    end
                    else
                    begin
                        state_reg <= S_DIV0;
                    end
                end
                S_DIV0:
                begin
                    cnt_reg   <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (cnt_reg == DIV_LAST)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_MQQ;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 5'd1;
                    end
                end
                S_MQQ: state_reg <= S_SQ2L;
                S_SQ2L:
                begin
                    cnt_reg   <= '0;
                    state_reg <= S_SQ2;
                end
                S_SQ2:
                begin
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == SQRT_LAST)
                        state_reg <= S_C1;
                end
                S_C1:
                begin
                    if (cnt_reg == CORDIC_LAST)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_C2;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 5'd1;
                    end
                end
                S_C2:
                begin
                    if (cnt_reg == CORDIC_LAST)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_SEL;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 5'd1;
                    end
                end
                S_SEL: state_reg <= S_OFS;
                S_OFS:
                begin
                    if (leg_reg == 2'd2)
                    begin
                        held_reg[0] <= nang_reg[0];
                        held_reg[1] <= nang_reg[1];
                        held_reg[2] <= ofs_sat;
                        status_reg  <= ST_OK;
                        failed_reg  <= '0;
                        state_reg   <= S_OUT;
                    end
                    else
                    begin
                        leg_reg   <= leg_reg + 2'd1;
                        state_reg <= S_LEG;
                    end
                end
                S_OUT:
                begin
                    if (out_ready)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // arithmetic datapath
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        case (state_reg)
            S_IDLE:
            begin
                x_reg <= target_x;
                y_reg <= target_y;
                z_reg <= target_z;
            end
            S_R2: px_reg <= 52'(prod_reg);
            S_R3: py_reg <= 52'(prod_reg);
            S_LEG:
            begin
                if (leg_reg == 2'd0)
                begin
                    rx_reg <= 22'(x_reg);
                    ry_reg <= 22'(y_reg);
                end
                else
                begin
                    rx_reg <= 22'(rx_sum >>> 30);
                    ry_reg <= 22'(ry_sum >>> 30);
                end
            end
            S_LY:
            begin
                yv_reg <= $signed({3'b000, base_reg}) + 23'(ry_reg)
                          - $signed({3'b000, plat_reg});
            end
            S_MZZ: rho_reg <= prod_reg[45:0];
            S_MRX: rho_reg <= rho_reg + prod_reg[45:0];
            S_MRE: n_reg <= -48'(prod_reg) - $signed({2'b00, rho_reg});
            S_MRF: n_reg <= n_reg + 48'(prod_reg);
            S_CHK:
            begin
                n_reg    <= n_reg - 48'(prod_reg);
                sv_reg   <= {2'b00, rho_reg, 16'd0};
                sres_reg <= '0;
                sone_reg <= SQRT_ONE;
            end
            S_SQ1, S_SQ2:
            begin
                if (sq_ge)
                begin
                    sv_reg   <= sv_reg - sq_sum;
                    sres_reg <= (sres_reg >> 1) + sone_reg;
                end
                else
                begin
                    sres_reg <= sres_reg >> 1;
                end
                sone_reg <= sone_reg >> 2;
                if (state_reg == S_SQ2 && cnt_reg == SQRT_LAST)
                begin
                    cx_reg   <= ld_cx;
                    cy_reg   <= ld_cy;
                    cacc_reg <= ld_acc;
                end
            end
            S_MDC:
            begin
                d_reg <= d_val;
                r_reg <= {1'b0, num_val};
            end
            S_DIV0:
            begin
                if (r_reg >= {1'b0, d_reg})
                begin
                    r_reg <= r_reg - {1'b0, d_reg};
                    q_reg <= 31'd1;
                end
                else
                begin
                    q_reg <= '0;
                end
            end
            S_DIV:
            begin
                if (dv_ge)
                begin
                    r_reg <= dv_r2 - {1'b0, d_reg};
                    q_reg <= {q_reg[29:0], 1'b1};
                end
                else
                begin
                    r_reg <= dv_r2;
                    q_reg <= {q_reg[29:0], 1'b0};
                end
            end
            S_SQ2L:
            begin
                sv_reg   <= ONE_Q60 - {3'b000, prod_reg[60:0]};
                sres_reg <= '0;
                sone_reg <= SQRT_ONE;
            end
            S_C1:
            begin
                if (cnt_reg == CORDIC_LAST)
                begin
                    phi_reg  <= c_acc_step;
                    cx_reg   <= ld_cx;
                    cy_reg   <= ld_cy;
                    cacc_reg <= ld_acc;
                end
                else
                begin
                    cx_reg   <= c_x_step;
                    cy_reg   <= c_y_step;
                    cacc_reg <= c_acc_step;
                end
            end
            S_C2:
            begin
                cx_reg   <= c_x_step;
                cy_reg   <= c_y_step;
                cacc_reg <= c_acc_step;
            end
            S_SEL: th_reg <= 21'(th_rnd);
            S_OFS:
            begin
                case (leg_reg)
                    2'd0:    nang_reg[0] <= ofs_sat;
                    2'd1:    nang_reg[1] <= ofs_sat;
                    default: nang_reg[2] <= ofs_sat;
                endcase
            end
            default:
            begin
            end
        endcase
    end

    // configuration writes
    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite && pready;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg   <= 20'd150000;
            plat_reg   <= 20'd60000;
            upper_reg  <= 20'd160000;
            lower_reg  <= 20'd200000;
            ofs_reg[0] <= '0;
            ofs_reg[1] <= '0;
            ofs_reg[2] <= '0;
        end
        else if (cfg_wr)
        begin
            case (paddr[4:2])
                REG_BASE:  base_reg   <= pwdata[19:0];
                REG_PLAT:  plat_reg   <= pwdata[19:0];
                REG_UPPER: upper_reg  <= pwdata[19:0];
                REG_LOWER: lower_reg  <= pwdata[19:0];
                REG_OFS0:  ofs_reg[0] <= $signed(pwdata[18:0]);
                REG_OFS1:  ofs_reg[1] <= $signed(pwdata[18:0]);
                REG_OFS2:  ofs_reg[2] <= $signed(pwdata[18:0]);
                default:
                begin
                end
            endcase
        end
    end

    // configuration reads
    always_comb
    begin
        case (paddr[4:2])
            REG_BASE:  prdata = {12'd0, base_reg};
            REG_PLAT:  prdata = {12'd0, plat_reg};
            REG_UPPER: prdata = {12'd0, upper_reg};
            REG_LOWER: prdata = {12'd0, lower_reg};
            REG_OFS0:  prdata = 32'(ofs_reg[0]);
            REG_OFS1:  prdata = 32'(ofs_reg[1]);
            REG_OFS2:  prdata = 32'(ofs_reg[2]);
            default:   prdata = '0;
        endcase
    end
    assign pready = 1'b1;

    // ports
    assign in_ready      = state_reg == S_IDLE;
    assign out_valid     = state_reg == S_OUT;
    assign motor_angle_0 = held_reg[0];
    assign motor_angle_1 = held_reg[1];
    assign motor_angle_2 = held_reg[2];
    assign status        = status_reg;
    assign failed_leg    = failed_reg;

    // terms used by the checks
    logic        held_in_range;
    logic        stop_req;
    logic        stop_done;
    logic        sing_chk;
    logic [59:0] held_pack;
    assign held_in_range = (held_reg[0] <= ANG_LIMIT) && (held_reg[0] >= -ANG_LIMIT)
                           && (held_reg[1] <= ANG_LIMIT) && (held_reg[1] >= -ANG_LIMIT)
                           && (held_reg[2] <= ANG_LIMIT) && (held_reg[2] >= -ANG_LIMIT);
    assign stop_req      = in_valid && in_ready && mode;
    assign stop_done     = (held_reg[0] == '0) && (held_reg[1] == '0) && (held_reg[2] == '0)
                           && (status_reg == ST_OK) && out_valid;
    assign sing_chk      = (state_reg == S_CHK) && (rho_reg == '0);
    assign held_pack     = {held_reg[0], held_reg[1], held_reg[2]};

    // checks
    `DAIK_ASSERT_IMP(a_one_side, out_valid, !in_ready, "result pending while ready")
    `DAIK_ASSERT_IMP(a_held_range, 1'b1, held_in_range, "held angle out of range")
    `DAIK_ASSERT_NXT(a_stop_zero, stop_req, stop_done, "stop did not zero angles")
    `DAIK_ASSERT_IMP(a_ok_leg, out_valid && (status_reg == ST_OK), failed_reg == 2'd0, "failed leg set on success")
    `DAIK_ASSERT_NXT(a_sing_keep, sing_chk, $stable(held_pack) && (status_reg == ST_SING), "singular leg changed angles")

endmodule

// ===== verif/tb_delta_arm_inverse_kinematics.sv =====
// testbench of the delta arm inverse kinematics block: directed table, random targets, predictor
module tb_delta_arm_inverse_kinematics;
    import daik_pkg::*;

    localparam int LIMIT_CYCLES = 12000000;
    localparam int MAX_REPORTS = 10;

    typedef struct {
        logic               mode;
        logic signed [20:0] x;
        logic signed [20:0] y;
        logic signed [20:0] z;
    } target_t;

    typedef struct {
        angle_t     a0;
        angle_t     a1;
        angle_t     a2;
        logic [1:0] st;
        logic [1:0] leg;
    } angles_t;

    typedef struct {
        target_t tgt;
        bit      typed;
        angles_t res;
    } row_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic               mode;
    logic signed [20:0] target_x;
    logic signed [20:0] target_y;
    logic signed [20:0] target_z;
    logic               out_valid;
    logic               out_ready;
    logic signed [19:0] motor_angle_0;
    logic signed [19:0] motor_angle_1;
    logic signed [19:0] motor_angle_2;
    logic [1:0]         status;
    logic [1:0]         failed_leg;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [4:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    delta_arm_inverse_kinematics u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .mode          (mode),
        .target_x      (target_x),
        .target_y      (target_y),
        .target_z      (target_z),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .motor_angle_0 (motor_angle_0),
        .motor_angle_1 (motor_angle_1),
        .motor_angle_2 (motor_angle_2),
        .status        (status),
        .failed_leg    (failed_leg),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // geometry and held angles as the block should see them
    bit [19:0] geo_base;
    bit [19:0] geo_plat;
    bit [19:0] geo_upper;
    bit [19:0] geo_lower;
    longint    geo_ofs [3];
    longint    held [3];

    longint arctan_steps [20] = '{720000, 425041, 224580, 114000, 57221, 28639, 14323,
                                  7162, 3581, 1790, 895, 448, 224, 112, 56, 28, 14, 7, 3, 2};

    angles_t   pending_angles [$];
    angles_t   typed_queue [$];
    bit        typed_flag [$];
    int        mismatches;
    bit        lost_result;
    longint    cycles;
    int        stall_left;
    bit        quiet_phase;

    // clock and cycle limit
    initial clk = 1'b0;
    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic bit [63:0] int_sqrt(input bit [63:0] v);
        bit [63:0] res;
        bit [63:0] one;
        begin
            res = 0;
            one = 64'd1 << 62;
            while (one > v)
                one = one >> 2;
            while (one != 0)
            begin
                if (v >= res + one)
                begin
                    v = v - (res + one);
                    res = (res >> 1) + one;
                end
                else
                    res = res >> 1;
                one = one >> 2;
            end
            return res;
        end
    endfunction

    // vectoring cordic, angle in 1/16 millidegree
    function automatic longint arctan2(input longint y, input longint x);
        longint acc;
        longint t;
        longint dx;
        longint dy;
        begin
            acc = 0;
            if (x < 0)
            begin
                t = x;
                if (y >= 0)
                begin
                    x = y;
                    y = -t;
                    acc = longint'(ANG_90);
                end
                else
                begin
                    x = -y;
                    y = t;
                    acc = -longint'(ANG_90);
                end
            end
            for (int i = 0; i < 20; i++)
            begin
                dx = x >>> i;
                dy = y >>> i;
                if (y > 0)
                begin
                    x = x + dy;
                    y = y - dx;
                    acc = acc + arctan_steps[i];
                end
                else
                begin
                    x = x - dy;
                    y = y + dx;
                    acc = acc - arctan_steps[i];
                end
            end
            return acc;
        end
    endfunction

    // elbow angle of one leg in millidegrees, returns the status code
    function automatic logic [1:0] leg_angle(input longint rx, input longint ry,
                                             input longint z, output longint ang);
        longint    yy;
        longint    rho_sq;
        longint    rf;
        longint    re;
        longint    n;
        longint    m;
        longint    th0;
        longint    th1;
        longint    delta;
        bit [63:0] d;
        bit [63:0] num;
        bit [63:0] r;
        bit [63:0] q;
        bit [63:0] s;
        begin
            ang = 0;
            yy = longint'(geo_base) + ry - longint'(geo_plat);
            rho_sq = yy * yy + z * z;
            rf = longint'(geo_upper);
            re = longint'(geo_lower);
            if (rho_sq == 0)
                return ST_SING;
            if (rf == 0)
                return ST_MISS;
            n = re * re - rx * rx - rf * rf - rho_sq;
            d = 64'd2 * rf * int_sqrt(rho_sq << 16);
            num = (n < 0 ? -n : n) << 8;
            if (num > d)
                return ST_MISS;
            r = num;
            q = 0;
            if (r >= d)
            begin
                q = 1;
                r = r - d;
            end
            for (int i = 0; i < 30; i++)
            begin
                r = r << 1;
                q = q << 1;
                if (r >= d)
                begin
                    r = r - d;
                    q[0] = 1'b1;
                end
            end
            m = n < 0 ? -longint'(q) : longint'(q);
            s = int_sqrt((64'd1 << 60) - q * q);
            delta = arctan2(longint'(s), m);
            th0 = arctan2(z * 256, yy * 256) + delta;
            th1 = th0 - 2 * delta;
            if ((th1 < 0 ? -th1 : th1) < (th0 < 0 ? -th0 : th0))
                th0 = th1;
            ang = (th0 + 8) >>> 4;
            return ST_OK;
        end
    endfunction

    // next held angles and status for one request
    function automatic angles_t solve_angles(input target_t t);
        angles_t   o;
        longint    x;
        longint    y;
        longint    sn;
        longint    hf;
        longint    rx [3];
        longint    ry [3];
        longint    ang [3];
        longint    a;
        logic [1:0] st;
        begin
            st = ST_OK;
            o.leg = 2'd0;
            if (t.mode)
            begin
                for (int k = 0; k < 3; k++)
                    held[k] = 0;
            end
            else
            begin
                x = t.x;
                y = t.y;
                sn = longint'(SIN120_Q30);
                hf = longint'(HALF_Q30);
                rx[0] = x;
                ry[0] = y;
                rx[1] = (-x * hf + y * sn + hf) >>> 30;
                ry[1] = (-x * sn - y * hf + hf) >>> 30;
                rx[2] = (-x * hf - y * sn + hf) >>> 30;
                ry[2] = (x * sn - y * hf + hf) >>> 30;
                for (int k = 0; k < 3; k++)
                begin
                    st = leg_angle(rx[k], ry[k], longint'(t.z), ang[k]);
                    if (st != ST_OK)
                    begin
                        o.leg = k[1:0];
                        break;
                    end
                end
                if (st == ST_OK)
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        a = ang[k] + geo_ofs[k];
                        if (a > longint'(ANG_LIMIT))
                            a = longint'(ANG_LIMIT);
                        if (a < -longint'(ANG_LIMIT))
                            a = -longint'(ANG_LIMIT);
                        held[k] = a;
                    end
                end
            end
            o.a0 = held[0][19:0];
            o.a1 = held[1][19:0];
            o.a2 = held[2][19:0];
            o.st = st;
            return o;
        end
    endfunction

    // register writes and accepted requests, seen at the clock edge
    always @(posedge clk)
    begin
        angles_t p;
        if (rst_n && psel && penable && pwrite && pready)
        begin
            case (paddr[4:2])
                REG_BASE:  geo_base = pwdata[19:0];
                REG_PLAT:  geo_plat = pwdata[19:0];
                REG_UPPER: geo_upper = pwdata[19:0];
                REG_LOWER: geo_lower = pwdata[19:0];
                REG_OFS0:  geo_ofs[0] = longint'(signed'(pwdata[18:0]));
                REG_OFS1:  geo_ofs[1] = longint'(signed'(pwdata[18:0]));
                REG_OFS2:  geo_ofs[2] = longint'(signed'(pwdata[18:0]));
                default:   ;
            endcase
        end
        if (rst_n && in_valid && in_ready)
        begin
            p = solve_angles('{mode, target_x, target_y, target_z});
            if (typed_flag.size() > 0 && typed_flag.pop_front())
                p = typed_queue.pop_front();
            pending_angles = {pending_angles, p};
        end
    end

    // result check against the oldest expectation
    always @(posedge clk)
    begin
        angles_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_angles.size() == 0)
            begin
                lost_result = 1'b1;
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: %0d %0d %0d st %0d leg %0d", motor_angle_0,
                             motor_angle_1, motor_angle_2, status, failed_leg);
            end
            else
            begin
                e = pending_angles.pop_front();
                if (e.a0 !== motor_angle_0 || e.a1 !== motor_angle_1 ||
                    e.a2 !== motor_angle_2 || e.st !== status || e.leg !== failed_leg)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("mismatch: exp %0d %0d %0d %0d %0d, got %0d %0d %0d %0d %0d",
                                 e.a0, e.a1, e.a2, e.st, e.leg, motor_angle_0, motor_angle_1,
                                 motor_angle_2, status, failed_leg);
                end
            end
        end
    end

    function automatic int idle_len();
        int r;
        begin
            r = $urandom_range(0, 99);
            if (quiet_phase || r < 65)
                return 0;
            if (r < 95)
                return $urandom_range(1, 3);
            return $urandom_range(10, 60);
        end
    endfunction

    // result side back-pressure
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
            stall_left <= idle_len();
        end
    end

    task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
        begin
            @(negedge clk);
            psel <= 1'b1;
            pwrite <= 1'b1;
            penable <= 1'b0;
            paddr <= {idx, 2'b00};
            pwdata <= val;
            @(negedge clk);
            penable <= 1'b1;
            @(negedge clk);
            psel <= 1'b0;
            penable <= 1'b0;
            pwrite <= 1'b0;
        end
    endtask

    task automatic load_geometry(input int b, input int p, input int u, input int l,
                                 input int o0, input int o1, input int o2);
        begin
            reg_write(REG_BASE, b);
            reg_write(REG_PLAT, p);
            reg_write(REG_UPPER, u);
            reg_write(REG_LOWER, l);
            reg_write(REG_OFS0, o0);
            reg_write(REG_OFS1, o1);
            reg_write(REG_OFS2, o2);
        end
    endtask

    task automatic send_request(input target_t t);
        int g;
        begin
            @(negedge clk);
            in_valid <= 1'b1;
            mode <= t.mode;
            target_x <= t.x;
            target_y <= t.y;
            target_z <= t.z;
            @(posedge clk);
            while (!in_ready)
                @(posedge clk);
            g = idle_len();
            if (g > 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (g - 1) @(negedge clk);
            end
        end
    endtask

    // drop the last request before waiting so that it is not taken twice
    task automatic drain();
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            while (pending_angles.size() != 0)
                @(negedge clk);
            repeat (10) @(negedge clk);
        end
    endtask

    function automatic int clamp_um(input longint v);
        begin
            if (v > 1000000)
                return 1000000;
            if (v < -1000000)
                return -1000000;
            return int'(v);
        end
    endfunction

    // mostly targets inside the work volume, some stops, aimed singularities and noise
    function automatic target_t pick_target();
        target_t t;
        int      r;
        int      reach;
        int      zlo;
        int      zhi;
        begin
            r = $urandom_range(0, 99);
            reach = int'(geo_upper) / 2 + 1;
            zlo = int'(geo_lower) / 2;
            zhi = int'(geo_lower) + int'(geo_upper) / 2;
            t.mode = 1'b0;
            t.x = 21'(clamp_um(int'($urandom_range(0, 2 * reach)) - reach));
            t.y = 21'(clamp_um(int'($urandom_range(0, 2 * reach)) - reach));
            t.z = 21'(clamp_um(-int'($urandom_range(zlo, zhi))));
            if (r < 10)
                t.mode = 1'b1;
            else if (r < 13)
            begin
                t.x = 21'(clamp_um(int'($urandom_range(0, 2000)) - 1000));
                t.y = 21'(clamp_um(longint'(geo_plat) - longint'(geo_base)));
                t.z = '0;
            end
            else if (r < 28)
            begin
                t.x = 21'(int'($urandom_range(0, 2000000)) - 1000000);
                t.y = 21'(int'($urandom_range(0, 2000000)) - 1000000);
                t.z = 21'(int'($urandom_range(0, 2000000)) - 1000000);
            end
            return t;
        end
    endfunction

    task automatic random_items(input int count);
        begin
            for (int i = 0; i < count; i++)
                send_request(pick_target());
        end
    endtask

    row_t directed [14];
    angles_t zero_ok;
    angles_t zero_sing;
    angles_t zero_miss;

    initial
    begin
        zero_ok = '{20'sd0, 20'sd0, 20'sd0, ST_OK, 2'd0};
        zero_sing = '{20'sd0, 20'sd0, 20'sd0, ST_SING, 2'd0};
        zero_miss = '{20'sd0, 20'sd0, 20'sd0, ST_MISS, 2'd0};
        // the first four rows (a stop, an on-axis target and two unreachable ones) have their results typed in
        directed = '{
            '{'{1'b1, 21'sd0, 21'sd0, 21'sd0}, 1'b1, zero_ok},
            '{'{1'b0, 21'sd0, -21'sd90000, 21'sd0}, 1'b1, zero_sing},
            '{'{1'b0, 21'sd1000000, 21'sd1000000, 21'sd1000000}, 1'b1, zero_miss},
            '{'{1'b0, -21'sd1000000, -21'sd1000000, -21'sd1000000}, 1'b1, zero_miss},
            '{'{1'b0, 21'sd0, 21'sd0, -21'sd200000}, 1'b0, zero_ok},
            '{'{1'b0, 21'sd0, 21'sd180000, 21'sd0}, 1'b0, zero_ok},
            '{'{1'b0, -21'sd103923, 21'sd0, 21'sd0}, 1'b0, zero_ok},
            '{'{1'b0, 21'sd50000, -21'sd40000, -21'sd180000}, 1'b0, zero_ok},
            '{'{1'b0, 21'sd1000000, 21'sd0, 21'sd0}, 1'b0, zero_ok},
            '{'{1'b0, 21'sd0, -21'sd1000000, 21'sd1000000}, 1'b0, zero_ok},
            '{'{1'b0, -21'sd60000, 21'sd70000, -21'sd250000}, 1'b0, zero_ok},
            '{'{1'b1, -21'sd1000000, 21'sd1000000, -21'sd1000000}, 1'b0, zero_ok},
            '{'{1'b0, 21'sd0, 21'sd0, -21'sd1}, 1'b0, zero_ok},
            '{'{1'b0, 21'sd1, -21'sd1, -21'sd150000}, 1'b0, zero_ok}
        };

        geo_base = 20'd150000;
        geo_plat = 20'd60000;
        geo_upper = 20'd160000;
        geo_lower = 20'd200000;
        for (int k = 0; k < 3; k++)
        begin
            geo_ofs[k] = 0;
            held[k] = 0;
        end
        mismatches = 0;
        lost_result = 1'b0;
        cycles = 0;
        stall_left = 0;
        quiet_phase = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        mode = 1'b0;
        target_x = '0;
        target_y = '0;
        target_z = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed part at reset geometry
        foreach (directed[i])
        begin
            typed_flag = {typed_flag, directed[i].typed};
            if (directed[i].typed)
                typed_queue = {typed_queue, directed[i].res};
            send_request(directed[i].tgt);
        end
        random_items(300);
        drain();

        // back to back on both sides with saturating offsets
        quiet_phase = 1'b1;
        load_geometry(150000, 60000, 160000, 200000, 180000, -180000, 90000);
        random_items(250);
        drain();
        quiet_phase = 1'b0;

        // smallest geometry
        load_geometry(0, 0, 1, 1, -180000, 0, 180000);
        random_items(120);
        drain();

        // largest in-range geometry
        load_geometry(1000000, 1000000, 1000000, 1000000, 12345, -54321, -180000);
        random_items(200);
        drain();

        // upper arm of zero length
        load_geometry(150000, 60000, 0, 200000, 0, 0, 0);
        random_items(60);
        drain();

        // full register width
        load_geometry(32'hFFFFF, 32'hFFFFF, 32'hFFFFF, 32'hFFFFF, 32'h7FFFF, 32'h40000, 32'h3FFFF);
        random_items(120);
        drain();

        // wide pivot circle, small effector
        load_geometry(300000, 20000, 250000, 450000, -5000, 7000, 0);
        random_items(350);
        drain();

        // reset geometry again
        load_geometry(150000, 60000, 160000, 200000, 0, 0, 0);
        random_items(300);
        drain();
        repeat (50) @(negedge clk);

        if (mismatches == 0 && !lost_result && pending_angles.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
